// File: hdl/snat_pkg.sv
// Package: constants, item types and register codes of the static NAT rewrite block.
`timescale 1ns / 1ps
`default_nettype none
package snat_pkg;

  localparam logic [15:0] MAGIC_RESET     = 16'h48F4;
  localparam logic [31:0] LOCAL_RESET     = 32'h0000_0000;
  localparam logic [15:0] SSH_PORT        = 16'd22;
  localparam logic [7:0]  PROTO_ICMP      = 8'd1;
  localparam logic [7:0]  PROTO_TCP       = 8'd6;
  localparam logic [7:0]  PROTO_UDP       = 8'd17;
  localparam logic [7:0]  ICMP_UNREACH    = 8'd3;
  localparam logic [7:0]  ICMP_TIME_EXCD  = 8'd11;
  localparam logic [7:0]  ICMP_PARAM_PROB = 8'd12;

  localparam int REG_STRIDE = 4;
  localparam int NUM_REGS   = 2;
  localparam int ADDR_W     = $clog2(REG_STRIDE * NUM_REGS);
  localparam int DATA_W     = 32;

  // register select, taken from paddr[2]
  localparam logic REG_MAGIC = 1'b0;
  localparam logic REG_LOCAL = 1'b1;

  typedef struct packed {
    logic        direction;
    logic [47:0] device_mac;
    logic [31:0] ip_source;
    logic [31:0] ip_destination;
    logic [15:0] ip_header_checksum;
    logic [7:0]  protocol_number;
    logic [12:0] fragment_offset;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [7:0]  icmp_kind;
    logic [15:0] transport_checksum;
    logic        l4_partial;
  } in_item_t;

  typedef struct packed {
    logic        rewritten;
    logic [31:0] new_ip_source;
    logic [31:0] new_ip_destination;
    logic [15:0] new_ip_header_checksum;
    logic [15:0] new_transport_checksum;
    logic        write_inner_address;
    logic [31:0] mapped_address;
  } out_item_t;

endpackage
`default_nettype wire

// File: hdl/snat_in_if.sv
// Interface: header item channel into the rewrite block.
`timescale 1ns / 1ps
`default_nettype none
interface snat_in_if;
  logic        valid;
  logic        ready;
  logic        direction;
  logic [47:0] device_mac;
  logic [31:0] ip_source;
  logic [31:0] ip_destination;
  logic [15:0] ip_header_checksum;
  logic [7:0]  protocol_number;
  logic [12:0] fragment_offset;
  logic [15:0] source_port;
  logic [15:0] destination_port;
  logic [7:0]  icmp_kind;
  logic [15:0] transport_checksum;
  logic        l4_partial;

  modport source (
    output valid, direction, device_mac, ip_source, ip_destination, ip_header_checksum,
           protocol_number, fragment_offset, source_port, destination_port, icmp_kind,
           transport_checksum, l4_partial,
    input  ready
  );

  modport sink (
    input  valid, direction, device_mac, ip_source, ip_destination, ip_header_checksum,
           protocol_number, fragment_offset, source_port, destination_port, icmp_kind,
           transport_checksum, l4_partial,
    output ready
  );
endinterface
`default_nettype wire

// File: hdl/snat_out_if.sv
// Interface: result item channel out of the rewrite block.
`timescale 1ns / 1ps
`default_nettype none
interface snat_out_if;
  logic        valid;
  logic        ready;
  logic        rewritten;
  logic [31:0] new_ip_source;
  logic [31:0] new_ip_destination;
  logic [15:0] new_ip_header_checksum;
  logic [15:0] new_transport_checksum;
  logic        write_inner_address;
  logic [31:0] mapped_address;

  modport source (
    output valid, rewritten, new_ip_source, new_ip_destination, new_ip_header_checksum,
           new_transport_checksum, write_inner_address, mapped_address,
    input  ready
  );

  modport sink (
    input  valid, rewritten, new_ip_source, new_ip_destination, new_ip_header_checksum,
           new_transport_checksum, write_inner_address, mapped_address,
    output ready
  );
endinterface
`default_nettype wire

// File: hdl/snat_csum.sv
// Incremental one's complement checksum update for a 32-bit address change.
`timescale 1ns / 1ps
`default_nettype none
module snat_csum (
  input  wire logic [15:0] check,
  input  wire logic        partial,
  input  wire logic [31:0] from_addr,
  input  wire logic [31:0] to_addr,
  output logic      [15:0] updated
);

  logic [15:0] seed;
  logic [31:0] from_n;
  logic [18:0] sum;
  logic [16:0] fold1;
  logic [15:0] fold2;

  // full update works on ~check and complements the result; partial sums stay plain
  always_comb begin
    seed   = partial ? check : ~check;
    from_n = ~from_addr;
    sum    = 19'(seed) + 19'(from_n[31:16]) + 19'(from_n[15:0])
           + 19'(to_addr[31:16]) + 19'(to_addr[15:0]);
    fold1  = 17'(sum[15:0]) + 17'(sum[18:16]);
    fold2  = fold1[15:0] + 16'(fold1[16]);
    updated = partial ? fold2 : ~fold2;
  end

endmodule
`default_nettype wire

// File: hdl/static_nat_header_rewrite_core.sv
// Top level: static one-to-one IPv4 NAT header rewrite with incremental checksums.
//
// header carries one IPv4 packet's header fields, its direction and the device MAC;
// result returns exactly one item per header item: the rewritten addresses and
// checksums, or the fields echoed with rewritten low when the packet passes.
// Both channels move an item at a rising edge with valid and ready high.
// An accepted item is captured in the input register, and its result is then
// loaded into the result register that drives result; one item per cycle is
// sustained while result is not stalled, set by the input register and the result
// register around the single-pass rewrite logic.
// When result is stalled the result register holds its item, the input register
// still takes one more item, and header.ready then falls until result drains.
// The APB port writes magic_prefix at 0x0 and local_address at 0x4; pready is
// always high, reads return the register value. Configuration is to be changed by
// the user only while no item is in flight; the block itself does not enforce it.
// rst (synchronous, active high) empties both registers and sets magic_prefix to
// 0x48F4 and local_address to 0.
`timescale 1ns / 1ps
`default_nettype none
module static_nat_header_rewrite_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  snat_in_if.sink                          header,
  snat_out_if.source                       result,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [snat_pkg::ADDR_W-1:0] paddr,
  input  wire logic [snat_pkg::DATA_W-1:0] pwdata,
  output logic      [snat_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);
  import snat_pkg::*;

  logic [15:0] magic_prefix;
  logic [31:0] local_address;

  logic        in_valid;
  in_item_t    in_q;
  logic        out_valid;
  out_item_t   out_q;
  out_item_t   out_next;

  logic        out_load;
  logic        in_take;
  logic        cfg_write;

  logic [31:0] map_addr;
  logic [31:0] old_addr;
  logic        pass;
  logic        is_tcp;
  logic        is_udp;
  logic        is_icmp;
  logic        icmp_err;
  logic [15:0] ip_upd;
  logic [15:0] l4_upd;
  logic [15:0] new_l4;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_LOCAL) ? local_address : {16'h0000, magic_prefix};

  // handshake
  assign out_load     = !out_valid || result.ready;
  assign in_take      = in_valid && out_load;
  assign header.ready = !in_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_prefix  <= MAGIC_RESET;
      local_address <= LOCAL_RESET;
      in_valid      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (paddr[2])
          REG_MAGIC: magic_prefix  <= pwdata[15:0];
          REG_LOCAL: local_address <= pwdata;
          default: ;
        endcase
      end
      if (header.ready) begin
        in_valid <= header.valid;
      end
      if (out_load) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (header.valid && header.ready) begin
      in_q.direction          <= header.direction;
      in_q.device_mac         <= header.device_mac;
      in_q.ip_source          <= header.ip_source;
      in_q.ip_destination     <= header.ip_destination;
      in_q.ip_header_checksum <= header.ip_header_checksum;
      in_q.protocol_number    <= header.protocol_number;
      in_q.fragment_offset    <= header.fragment_offset;
      in_q.source_port        <= header.source_port;
      in_q.destination_port   <= header.destination_port;
      in_q.icmp_kind          <= header.icmp_kind;
      in_q.transport_checksum <= header.transport_checksum;
      in_q.l4_partial         <= header.l4_partial;
    end
    if (in_take) begin
      out_q <= out_next;
    end
  end

  snat_csum u_ip_csum (
    .check     (in_q.ip_header_checksum),
    .partial   (1'b0),
    .from_addr (old_addr),
    .to_addr   (map_addr),
    .updated   (ip_upd)
  );

  snat_csum u_l4_csum (
    .check     (in_q.transport_checksum),
    .partial   (in_q.l4_partial),
    .from_addr (old_addr),
    .to_addr   (map_addr),
    .updated   (l4_upd)
  );

  always_comb begin
    map_addr = in_q.direction ? local_address : in_q.device_mac[31:0];
    old_addr = in_q.direction ? in_q.ip_source : in_q.ip_destination;
    is_tcp   = (in_q.protocol_number == PROTO_TCP);
    is_udp   = (in_q.protocol_number == PROTO_UDP);
    is_icmp  = (in_q.protocol_number == PROTO_ICMP);
    icmp_err = in_q.icmp_kind inside {ICMP_UNREACH, ICMP_TIME_EXCD, ICMP_PARAM_PROB};

    pass = (in_q.device_mac[47:32] != magic_prefix) || (map_addr == 32'h0)
        || (in_q.fragment_offset != 13'h0)
        || (is_tcp && ((in_q.source_port == SSH_PORT) || (in_q.destination_port == SSH_PORT)))
        || !(is_tcp || is_udp || is_icmp);

    new_l4 = in_q.transport_checksum;
    if (is_tcp) begin
      new_l4 = l4_upd;
    end else if (is_udp) begin
      // zero UDP checksum means none, unless it holds a partial sum
      if ((in_q.transport_checksum != 16'h0) || in_q.l4_partial) begin
        new_l4 = (l4_upd == 16'h0) ? 16'hFFFF : l4_upd;
      end
    end else if (is_icmp && icmp_err && !in_q.l4_partial) begin
      new_l4 = l4_upd;
    end

    if (pass) begin
      out_next.rewritten              = 1'b0;
      out_next.new_ip_source          = in_q.ip_source;
      out_next.new_ip_destination     = in_q.ip_destination;
      out_next.new_ip_header_checksum = in_q.ip_header_checksum;
      out_next.new_transport_checksum = in_q.transport_checksum;
      out_next.write_inner_address    = 1'b0;
      out_next.mapped_address         = 32'h0;
    end else begin
      out_next.rewritten              = 1'b1;
      out_next.new_ip_source          = in_q.direction ? map_addr : in_q.ip_source;
      out_next.new_ip_destination     = in_q.direction ? in_q.ip_destination : map_addr;
      out_next.new_ip_header_checksum = ip_upd;
      out_next.new_transport_checksum = new_l4;
      out_next.write_inner_address    = is_icmp && icmp_err;
      out_next.mapped_address         = map_addr;
    end
  end

  assign result.valid                  = out_valid;
  assign result.rewritten              = out_q.rewritten;
  assign result.new_ip_source          = out_q.new_ip_source;
  assign result.new_ip_destination     = out_q.new_ip_destination;
  assign result.new_ip_header_checksum = out_q.new_ip_header_checksum;
  assign result.new_transport_checksum = out_q.new_transport_checksum;
  assign result.write_inner_address    = out_q.write_inner_address;
  assign result.mapped_address         = out_q.mapped_address;

endmodule
`default_nettype wire

// File: hdl/snat_checker.sv
// Checker: port-level assertions for the rewrite block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module snat_checker (
  input  wire logic  clk,
  input  wire logic  rst,
  snat_out_if.source result
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> result.valid && $stable(result.rewritten)
      && $stable(result.new_ip_source) && $stable(result.new_ip_destination)
      && $stable(result.new_ip_header_checksum) && $stable(result.new_transport_checksum)
      && $stable(result.write_inner_address) && $stable(result.mapped_address))
    else $error("stalled result item changed");

  a_pass_clean: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.rewritten |-> (result.mapped_address == 32'h0)
      && !result.write_inner_address)
    else $error("passed item carries a mapping");

  a_mapped_used: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.rewritten |-> (result.mapped_address != 32'h0)
      && ((result.new_ip_source == result.mapped_address)
      || (result.new_ip_destination == result.mapped_address)))
    else $error("rewritten item lacks mapped address");

  a_inner_rewritten: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.write_inner_address |-> result.rewritten)
    else $error("inner write on item that was not rewritten");

endmodule

bind static_nat_header_rewrite_core snat_checker u_snat_checker (
  .clk    (clk),
  .rst    (rst),
  .result (result)
);
`default_nettype wire
